// ===== src/pfd_pkg.sv =====
`default_nettype none

package pfd_pkg;

  // Number of channels in one frame (1 to 16).
  localparam int unsigned CHANNEL_COUNT = 8;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // The channel counter must also hold CHANNEL_COUNT, which means awaiting sync.
  localparam int unsigned CNT_W  = $clog2(CHANNEL_COUNT + 1);
  localparam int unsigned ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(CHANNEL_COUNT);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(CHANNEL_COUNT - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_MAX = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MIN = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_MAX = 8'd3;

  localparam logic [TIME_W-1:0] SYNC_MIN_RST = 32'd5000;
  localparam logic [TIME_W-1:0] SYNC_MAX_RST = 32'd15000;
  localparam logic [TICK_W-1:0] DATA_MIN_RST = 16'd800;
  localparam logic [TICK_W-1:0] DATA_MAX_RST = 16'd2200;

  typedef struct packed {
    logic [TIME_W-1:0] sync_min;
    logic [TIME_W-1:0] sync_max;
    logic [TICK_W-1:0] data_min;
    logic [TICK_W-1:0] data_max;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD,
    ST_LOAD
  } state_e;

endpackage

`default_nettype wire

// ===== src/pfd_ram.sv =====
`default_nettype none

module pfd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/pfd_cfg_regs.sv =====
`default_nettype none

module pfd_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pfd_pkg::cfg_t                       cfg_o
);

  pfd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfd_pkg::REG_SYNC_MIN: cfg_d.sync_min = cfg_data_i;
        pfd_pkg::REG_SYNC_MAX: cfg_d.sync_max = cfg_data_i;
        pfd_pkg::REG_DATA_MIN: cfg_d.data_min = cfg_data_i[pfd_pkg::TICK_W-1:0];
        pfd_pkg::REG_DATA_MAX: cfg_d.data_max = cfg_data_i[pfd_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_min <= pfd_pkg::SYNC_MIN_RST;
      cfg_q.sync_max <= pfd_pkg::SYNC_MAX_RST;
      cfg_q.data_min <= pfd_pkg::DATA_MIN_RST;
      cfg_q.data_max <= pfd_pkg::DATA_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfd_core.sv =====
`default_nettype none

module pfd_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire pfd_pkg::cfg_t               cfg_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [pfd_pkg::TIME_W-1:0]  in_time_i,
  input  wire logic                        in_rssi_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [pfd_pkg::IDX_W-1:0]   out_idx_o,
  output logic      [pfd_pkg::TICK_W-1:0]  out_ticks_o,
  output logic                             out_last_o
);

  pfd_pkg::state_e state_q, state_d;

  logic [pfd_pkg::TIME_W-1:0] prev_q, prev_d;
  logic [pfd_pkg::TIME_W-1:0] interval_q, interval_d;
  logic                       rssi_q, rssi_d;
  logic [pfd_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [pfd_pkg::CNT_W-1:0]  cnt_inc;
  logic                       cmpl_q, cmpl_d;
  logic [pfd_pkg::ADDR_W-1:0] rel_idx_q, rel_idx_d;

  logic                       out_valid_q, out_valid_d;
  logic [pfd_pkg::IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [pfd_pkg::TICK_W-1:0] out_ticks_q, out_ticks_d;
  logic                       out_last_q, out_last_d;

  logic                       ram_we, ram_re;
  logic [pfd_pkg::TICK_W-1:0] ram_rdata;

  logic awaiting, sync_hit, data_hit, out_free;

  assign awaiting = (cnt_q >= pfd_pkg::CNT_FULL);
  assign sync_hit = (interval_q > cfg_i.sync_min) && (interval_q < cfg_i.sync_max);
  assign data_hit = (interval_q > pfd_pkg::TIME_W'(cfg_i.data_min))
                 && (interval_q < pfd_pkg::TIME_W'(cfg_i.data_max));
  assign cnt_inc  = cnt_q + 1'b1;
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == pfd_pkg::ST_IDLE);

  pfd_ram #(
    .Width (pfd_pkg::TICK_W),
    .Depth (pfd_pkg::CHANNEL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[pfd_pkg::ADDR_W-1:0]),
    .wdata_i (interval_q[pfd_pkg::TICK_W-1:0]),
    .re_i    (ram_re),
    .raddr_i (rel_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    prev_d      = prev_q;
    interval_d  = interval_q;
    rssi_d      = rssi_q;
    cnt_d       = cnt_q;
    cmpl_d      = cmpl_q;
    rel_idx_d   = rel_idx_q;
    out_idx_d   = out_idx_q;
    out_ticks_d = out_ticks_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      pfd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          interval_d = in_time_i - prev_q;
          prev_d     = in_time_i;
          rssi_d     = in_rssi_i;
          state_d    = pfd_pkg::ST_EVAL;
        end
      end
      pfd_pkg::ST_EVAL: begin
        state_d = pfd_pkg::ST_IDLE;
        if (awaiting) begin
          if (sync_hit) begin
            if (cmpl_q && rssi_q) begin
              cmpl_d    = 1'b0;
              rel_idx_d = '0;
              state_d   = pfd_pkg::ST_RD;
            end
            cnt_d = '0;
          end else begin
            cmpl_d = 1'b0;
          end
        end else if (data_hit) begin
          ram_we = 1'b1;
          cnt_d  = cnt_inc;
          if (cnt_inc == pfd_pkg::CNT_FULL) begin
            cmpl_d = 1'b1;
          end
        end else begin
          cnt_d  = pfd_pkg::CNT_FULL;
          cmpl_d = 1'b0;
        end
      end
      pfd_pkg::ST_RD: begin
        ram_re  = 1'b1;
        state_d = pfd_pkg::ST_LOAD;
      end
      pfd_pkg::ST_LOAD: begin
        // The read data stays put until the output register has room.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = pfd_pkg::IDX_W'(rel_idx_q);
          out_ticks_d = ram_rdata;
          out_last_d  = (rel_idx_q == pfd_pkg::ADDR_LAST);
          if (rel_idx_q == pfd_pkg::ADDR_LAST) begin
            state_d = pfd_pkg::ST_IDLE;
          end else begin
            rel_idx_d = rel_idx_q + 1'b1;
            state_d   = pfd_pkg::ST_RD;
          end
        end
      end
      default: state_d = pfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfd_pkg::ST_IDLE;
      prev_q      <= '0;
      cnt_q       <= pfd_pkg::CNT_FULL;
      cmpl_q      <= 1'b0;
      rel_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      cmpl_q      <= cmpl_d;
      rel_idx_q   <= rel_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    interval_q  <= interval_d;
    rssi_q      <= rssi_d;
    out_idx_q   <= out_idx_d;
    out_ticks_q <= out_ticks_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_ticks_o = out_ticks_q;
  assign out_last_o  = out_last_q;

  a_write_only_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == pfd_pkg::ST_EVAL) && (cnt_q < pfd_pkg::CNT_FULL))
    else $error("channel store written outside of a collecting evaluation");

  a_release_needs_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfd_pkg::ST_EVAL && state_d == pfd_pkg::ST_RD) |-> cmpl_q && rssi_q)
    else $error("release started without a complete frame and good signal");

  a_load_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfd_pkg::ST_LOAD) |->
      ($past(state_q) == pfd_pkg::ST_RD || $past(state_q) == pfd_pkg::ST_LOAD))
    else $error("output load without a preceding memory read");

  a_release_restarts_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfd_pkg::ST_RD) |-> (cnt_q == '0 || cnt_q < pfd_pkg::CNT_FULL) && !cmpl_q)
    else $error("release in progress while frame state is inconsistent");

endmodule

`default_nettype wire

// ===== src/ppm_frame_decoder_top.sv =====
// PPM frame decoder.
// The s_axis channel takes one word per pulse edge: the captured 32-bit tick
// count in tdata and the signal-quality flag in tuser. The block measures the
// interval since the previous edge, detects sync gaps and collects channel
// widths into a small on-chip store. When a sync gap follows a complete frame
// and the quality flag is high, the m_axis channel delivers one word per
// channel in order, index in tuser, width in tdata, tlast on the final one.
// An edge word is evaluated in the cycle after it is accepted; an edge that
// releases nothing then frees the input. A releasing edge instead reads each
// channel in turn from the store's single registered read port and loads it
// into the output register, alternating a read state and a load state per
// word. The input stays closed until the last word of a frame is in the
// output register. When the receiver stalls, the output word holds and the
// release pauses. Reset restores the default limits, clears the previous edge
// time to zero and leaves the decoder awaiting sync with no complete frame.
// The cfg channel is always ready; it is to be written while the decoder is
// idle, a rule for the user that the block itself does not enforce.
`default_nettype none

module ppm_frame_decoder_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [31:0]                    s_axis_tdata,  // edge_time
  input  wire logic [0:0]                     s_axis_tuser,  // rssi_ok
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [15:0]                    m_axis_tdata,  // pulse_ticks
  output logic      [3:0]                     m_axis_tuser,  // channel_index
  output logic                                m_axis_tlast
);

  pfd_pkg::cfg_t cfg;

  pfd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_time_i   (s_axis_tdata),
    .in_rssi_i   (s_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_idx_o   (m_axis_tuser),
    .out_ticks_o (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 20000;
  // Quiet wait after the output queue drains, sized from the channel count.
  localparam int unsigned QUIET_CYC   = 2 * (2 + 2 * pfd_pkg::CHANNEL_COUNT);

  // Register indexes past the end of the map; writes to them are ignored.
  localparam logic [pfd_pkg::CFG_IDX_W-1:0] REG_PAST_END = 8'd4;
  localparam logic [pfd_pkg::CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

  typedef struct packed {
    logic [pfd_pkg::IDX_W-1:0]  idx;
    logic [pfd_pkg::TICK_W-1:0] ticks;
    logic                       last;
  } chan_word_t;

  typedef struct packed {
    logic [pfd_pkg::TIME_W-1:0] delta;
    logic                       rssi;
    logic [4:0]                 n_words;
  } edge_row_t;

  typedef struct packed {
    logic [pfd_pkg::CFG_DATA_W-1:0] sync_min;
    logic [pfd_pkg::CFG_DATA_W-1:0] sync_max;
    logic [pfd_pkg::CFG_DATA_W-1:0] data_min;
    logic [pfd_pkg::CFG_DATA_W-1:0] data_max;
    logic [15:0]                    n_items;
  } limit_set_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [pfd_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [31:0]                    s_axis_tdata;   // edge_time
  logic [0:0]                     s_axis_tuser;   // rssi_ok
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [15:0]                    m_axis_tdata;   // pulse_ticks
  logic [3:0]                     m_axis_tuser;   // channel_index
  logic                           m_axis_tlast;

  ppm_frame_decoder_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Decoder shadow state.
  pfd_pkg::cfg_t              lim;
  logic [pfd_pkg::TIME_W-1:0] last_edge_t;
  int unsigned                chan_pos;
  logic                       frame_full;
  logic [pfd_pkg::TICK_W-1:0] width_mem [pfd_pkg::CHANNEL_COUNT];
  chan_word_t                 pulse_q [$];

  int                         err_cnt;
  int unsigned                cycle_cnt;
  logic [pfd_pkg::TIME_W-1:0] drv_time;
  int                         burst_left;

  // Directed edges, given as the interval from the previous edge.
  localparam int DIR_N = 24;
  edge_row_t dir_rows [DIR_N] = '{
    '{32'd0,          1'b0, 5'd0},   // edge time zero, zero interval
    '{32'hFFFF_FFFF,  1'b1, 5'd0},   // edge time at its maximum
    '{32'd10000,      1'b1, 5'd0},   // sync across the counter wrap
    '{32'd801,        1'b0, 5'd0},
    '{32'd2199,       1'b1, 5'd0},
    '{32'd1000,       1'b0, 5'd0},
    '{32'd1500,       1'b1, 5'd0},
    '{32'd1200,       1'b1, 5'd0},
    '{32'd1800,       1'b0, 5'd0},
    '{32'd900,        1'b1, 5'd0},
    '{32'd2000,       1'b1, 5'd0},
    '{32'd10000,      1'b0, 5'd0},   // sync with poor quality holds the frame back
    '{32'd2200,       1'b1, 5'd0},   // channel at the upper bound aborts
    '{32'd15000,      1'b1, 5'd0},   // gap at the sync upper bound is no sync
    '{32'd5001,       1'b1, 5'd0},
    '{32'd2199,       1'b0, 5'd0},
    '{32'd801,        1'b1, 5'd0},
    '{32'd1300,       1'b0, 5'd0},
    '{32'd1700,       1'b1, 5'd0},
    '{32'd1050,       1'b0, 5'd0},
    '{32'd1950,       1'b1, 5'd0},
    '{32'd1400,       1'b0, 5'd0},
    '{32'd1600,       1'b1, 5'd0},
    '{32'd14999,      1'b1, 5'd8}    // full frame released
  };

  localparam int PHASE_N = 6;
  limit_set_t phases [PHASE_N] = '{
    '{32'd5000,       32'd15000,      32'd800,        32'd2200,       16'd60},
    // Widest window; upper data bits must be dropped by the block.
    '{32'd0,          32'hFFFF_FFFF,  32'hABCD_0000,  32'h5A5A_FFFF,  16'd50},
    // Nothing fits strictly between either pair of bounds.
    '{32'd100,        32'd101,        32'd1500,       32'd1501,       16'd20},
    '{32'd20000,      32'd40000,      32'd1000,       32'd2000,       16'd60},
    '{32'hFFFF_0000,  32'hFFFF_FFFF,  32'd65000,      32'd65535,      16'd50},
    '{32'd5000,       32'd15000,      32'd800,        32'd2200,       16'd40}
  };

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    cycle_cnt = 0;
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int decode_edge(input logic [pfd_pkg::TIME_W-1:0] t, input logic rssi);
    logic [pfd_pkg::TIME_W-1:0] gap;
    chan_word_t                 w;
    int                         n;
    gap = t - last_edge_t;
    last_edge_t = t;
    n = 0;
    if (chan_pos >= pfd_pkg::CHANNEL_COUNT) begin
      if (gap > lim.sync_min && gap < lim.sync_max) begin
        if (frame_full && rssi) begin
          for (int k = 0; k < pfd_pkg::CHANNEL_COUNT; k++) begin
            w.idx   = pfd_pkg::IDX_W'(k);
            w.ticks = width_mem[k];
            w.last  = (k == pfd_pkg::CHANNEL_COUNT - 1);
            pulse_q.push_back(w);
          end
          n = pfd_pkg::CHANNEL_COUNT;
          frame_full = 1'b0;
        end
        chan_pos = 0;
      end else begin
        frame_full = 1'b0;
      end
    end else begin
      if (gap > {16'b0, lim.data_min} && gap < {16'b0, lim.data_max}) begin
        width_mem[chan_pos] = gap[pfd_pkg::TICK_W-1:0];
        chan_pos++;
        if (chan_pos == pfd_pkg::CHANNEL_COUNT) frame_full = 1'b1;
      end else begin
        chan_pos = pfd_pkg::CHANNEL_COUNT;
        frame_full = 1'b0;
      end
    end
    return n;
  endfunction

  // Sender works in bursts; a gap of zero keeps words back to back.
  task automatic send_edge(input logic [pfd_pkg::TIME_W-1:0] delta, input logic rssi,
                           output int n_words);
    logic [pfd_pkg::TIME_W-1:0] t;
    int                         gap;
    t = drv_time + delta;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    s_axis_tuser  <= rssi;
    do @(posedge clk_i); while (!s_axis_tready);
    drv_time = t;
    n_words = decode_edge(t, rssi);
  endtask

  task automatic write_reg(input logic [pfd_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [pfd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pfd_pkg::REG_SYNC_MIN: lim.sync_min = val;
      pfd_pkg::REG_SYNC_MAX: lim.sync_max = val;
      pfd_pkg::REG_DATA_MIN: lim.data_min = val[pfd_pkg::TICK_W-1:0];
      pfd_pkg::REG_DATA_MAX: lim.data_max = val[pfd_pkg::TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pulse_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  // Strictly between lo and hi, leaning on the bounds now and then; a random value when nothing lies between them.
  function automatic logic [pfd_pkg::TIME_W-1:0] pick_between(
      input logic [pfd_pkg::TIME_W-1:0] lo,
      input logic [pfd_pkg::TIME_W-1:0] hi);
    int r;
    if ({1'b0, hi} <= {1'b0, lo} + 33'd1) return $urandom;
    r = $urandom_range(0, 9);
    if (r == 0) return lo + 1;
    if (r == 1) return hi - 1;
    return $urandom_range(hi - 1, lo + 1);
  endfunction

  function automatic logic [pfd_pkg::TIME_W-1:0] noise_gap(
      input logic [pfd_pkg::TIME_W-1:0] lo,
      input logic [pfd_pkg::TIME_W-1:0] hi);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return lo;
      2:       return hi;
      default: return $urandom_range(3000, 0);
    endcase
  endfunction

  // Mostly well-formed frames with random widths; some frames are broken
  // at a random channel, and some edges are plain noise.
  task automatic run_random(input int n);
    int sent;
    int brk;
    int dummy;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        send_edge(pick_between(lim.sync_min, lim.sync_max), $urandom_range(0, 9) != 0, dummy);
        brk = ($urandom_range(0, 6) == 0) ? $urandom_range(0, pfd_pkg::CHANNEL_COUNT - 1)
                                          : pfd_pkg::CHANNEL_COUNT;
        for (int k = 0; k < pfd_pkg::CHANNEL_COUNT; k++) begin
          if (k == brk)
            send_edge(noise_gap({16'b0, lim.data_min}, {16'b0, lim.data_max}),
                      $urandom_range(0, 1), dummy);
          else
            send_edge(pick_between({16'b0, lim.data_min}, {16'b0, lim.data_max}),
                      $urandom_range(0, 1), dummy);
        end
        sent += 1 + pfd_pkg::CHANNEL_COUNT;
      end else begin
        send_edge(noise_gap(lim.sync_min, lim.sync_max), $urandom_range(0, 1), dummy);
        sent++;
      end
    end
  endtask

  // Receiver stall pattern: switches among always ready, mostly ready,
  // a fixed two-on two-off rhythm and long stalls.
  initial begin : rx_stall
    int mode;
    int span;
    int step;
    m_axis_tready = 1'b0;
    step = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk_i);
        step++;
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= step[1];
          default: m_axis_tready <= ($urandom_range(0, 19) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : chk_out
    chan_word_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pulse_q.size() == 0) begin
        $error("unexpected channel word: index %0d ticks %0d", m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        w = pulse_q.pop_front();
        if (m_axis_tuser !== w.idx) begin
          $error("channel_index: expected %0d, got %0d", w.idx, m_axis_tuser);
          err_cnt++;
        end
        if (m_axis_tdata !== w.ticks) begin
          $error("pulse_ticks: expected %0d, got %0d", w.ticks, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("last: expected %0b, got %0b", w.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin : stim
    int n;
    int waited;
    err_cnt       = 0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    lim.sync_min  = pfd_pkg::SYNC_MIN_RST;
    lim.sync_max  = pfd_pkg::SYNC_MAX_RST;
    lim.data_min  = pfd_pkg::DATA_MIN_RST;
    lim.data_max  = pfd_pkg::DATA_MAX_RST;
    last_edge_t   = '0;
    chan_pos      = pfd_pkg::CHANNEL_COUNT;
    frame_full    = 1'b0;
    drv_time      = '0;
    burst_left    = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      send_edge(dir_rows[i].delta, dir_rows[i].rssi, n);
      if (n != dir_rows[i].n_words) begin
        $error("edge %0d: expected %0d channel words, predicted %0d",
               i, dir_rows[i].n_words, n);
        err_cnt++;
      end
    end

    for (int p = 0; p < PHASE_N; p++) begin
      wait_quiet();
      if (p == 2) begin
        write_reg(REG_PAST_END, $urandom);
        write_reg(REG_TOP_IDX, $urandom);
      end
      write_reg(pfd_pkg::REG_SYNC_MIN, phases[p].sync_min);
      write_reg(pfd_pkg::REG_SYNC_MAX, phases[p].sync_max);
      write_reg(pfd_pkg::REG_DATA_MIN, phases[p].data_min);
      write_reg(pfd_pkg::REG_DATA_MAX, phases[p].data_max);
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      run_random(phases[p].n_items);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pulse_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (QUIET_CYC) @(posedge clk_i);
    if (pulse_q.size() != 0) begin
      $error("%0d channel words never arrived", pulse_q.size());
      err_cnt++;
    end

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
